// ===== hw/rtl/b64d_pkg.sv =====
// Shared types, character constants and the alphabet lookup for the base64 stream decoder.
// Has no dependencies; every other RTL file imports it.
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_DIGIT_0 = 8'd48;
    localparam logic [7:0] CH_DIGIT_9 = 8'd57;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_SLASH   = 8'd47;

    localparam logic [7:0] LOWER_OFFSET = 8'd71;
    localparam logic [7:0] DIGIT_OFFSET = 8'd4;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // One decoded character handed from the front to the back.
    typedef struct packed {
        logic [1:0] pos;
        logic [5:0] sextet;
    } sextet_entry_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sextet_lookup_t;

    function automatic sextet_lookup_t sextet_of(input logic [7:0] ch);
        sextet_lookup_t r;
        logic [7:0]     t;
        r = '0;
        t = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            t = ch - CH_UPPER_A;
            r.valid = 1'b1;
            r.value = t[5:0];
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            t = ch - LOWER_OFFSET;
            r.valid = 1'b1;
            r.value = t[5:0];
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            t = ch + DIGIT_OFFSET;
            r.valid = 1'b1;
            r.value = t[5:0];
        end else if (ch == CH_PLUS) begin
            r.valid = 1'b1;
            r.value = SEXTET_PLUS;
        end else if (ch == CH_SLASH) begin
            r.valid = 1'b1;
            r.value = SEXTET_SLASH;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64d_front.sv =====
// Front end of the base64 stream decoder: accepts characters, classifies them
// and tracks group position and the stop flag. Depends on b64d_pkg.
`default_nettype none

module b64d_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [7:0]              in_char,
    input  wire logic                    q_full,
    output logic                         q_push,
    output b64d_pkg::sextet_entry_t      q_entry
);
    import b64d_pkg::*;

    logic [1:0]     group_pos_reg, group_pos_next;
    logic           stopped_reg, stopped_next;
    logic           accept;
    sextet_lookup_t lk;

    assign lk       = sextet_of(in_char);
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Only characters that still decode are queued; the rest are dropped here.
    assign q_push         = accept && !stopped_reg && lk.valid;
    assign q_entry.pos    = group_pos_reg;
    assign q_entry.sextet = lk.value;

    always_comb begin
        group_pos_next = group_pos_reg;
        stopped_next   = stopped_reg;
        if (accept) begin
            group_pos_next = group_pos_reg + 2'd1;
            if (group_pos_reg == POS_FOURTH) begin
                stopped_next = 1'b0;
            end else begin
                stopped_next = stopped_reg || !lk.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_pos_reg <= POS_FIRST;
            stopped_reg   <= 1'b0;
        end else begin
            group_pos_reg <= group_pos_next;
            stopped_reg   <= stopped_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_fifo.sv =====
// Short queue between the front and back of the base64 stream decoder.
// Holds sextet entries in a small register array; depends on b64d_pkg.
`default_nettype none

module b64d_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire b64d_pkg::sextet_entry_t push_entry,
    output logic                         full,
    input  wire logic                    pop,
    output logic                         not_empty,
    output b64d_pkg::sextet_entry_t      head_entry
);
    import b64d_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sextet_entry_t mem_reg [DEPTH];
    logic [IW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign not_empty  = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + IW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + IW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_back.sv =====
// Back end of the base64 stream decoder: packs queued sextets into bytes and
// holds each byte in the output register. Depends on b64d_pkg.
`default_nettype none

module b64d_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    q_not_empty,
    input  wire b64d_pkg::sextet_entry_t q_head,
    output logic                         q_pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [7:0]                   out_byte
);
    import b64d_pkg::*;

    logic [5:0] carry_reg, carry_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       out_free;
    logic       emits;

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_free  = !valid_reg || out_ready;
    assign emits     = (q_head.pos != POS_FIRST);
    // The first character of a group only loads the carry, so it never waits.
    assign q_pop     = q_not_empty && (!emits || out_free);

    always_comb begin
        carry_next = carry_reg;
        byte_next  = byte_reg;
        valid_next = valid_reg && !out_ready;
        if (q_pop) begin
            case (q_head.pos)
                POS_FIRST: begin
                    carry_next = q_head.sextet;
                end
                POS_SECOND: begin
                    byte_next  = {carry_reg, q_head.sextet[5:4]};
                    carry_next = {2'b00, q_head.sextet[3:0]};
                    valid_next = 1'b1;
                end
                POS_THIRD: begin
                    byte_next  = {carry_reg[3:0], q_head.sextet[5:2]};
                    carry_next = {4'b0000, q_head.sextet[1:0]};
                    valid_next = 1'b1;
                end
                default: begin
                    byte_next  = {carry_reg[1:0], q_head.sextet};
                    carry_next = '0;
                    valid_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            carry_reg <= carry_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/base64_stream_decoder.sv =====
// Top level of the base64 stream decoder: front classifier, sextet queue and
// byte packer. Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
`default_nettype none

// Channel  | Direction | Ports                               | Payload
// ---------+-----------+-------------------------------------+----------------------
// input    | slave     | s_axis_tvalid/tready/tdata[7:0]     | char_code (one ASCII)
// result   | master    | m_axis_tvalid/tready/tdata[7:0]     | data_byte (raw byte)
//
// One character transfer is taken every cycle while the queue has room; the
// back end packs one sextet per cycle unless a stalled result channel holds it,
// so the sustained rate is one item per cycle. A decoded byte loads into the
// output register at the edge at which its sextet leaves the queue, so it shows
// on the result channel after the queue and can be taken at the following edge.
// Reset (aresetn low at a clock edge) clears group position, stop flag, queue,
// carry and output valid flag. A stalled result channel fills the queue, after which
// s_axis_tready drops; the output register lets a new byte load as one leaves.

module base64_stream_decoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_code
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [7:0] data_byte
);
    import b64d_pkg::*;

    sextet_entry_t push_entry;
    sextet_entry_t head_entry;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_not_empty;

    // Front: classifies each character and drops invalid ones and those after a stop in the group.
    b64d_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_char  (s_axis_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    // Queue: lets the front keep taking characters while the result side stalls.
    b64d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_entry (head_entry)
    );

    // Back: joins sextets into bytes, most significant bits first.
    b64d_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (head_entry),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for base64_stream_decoder: character streams in, decoded bytes out.
// Needs only the decoder RTL; the expected byte stream comes from a behavioral decoder below.
`timescale 1ns / 100ps

module testbench;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    // Alphabet boundaries and sextet values of the two symbol characters.
    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_ZERO    = 8'd48;
    localparam logic [7:0] ASCII_PLUS    = 8'd43;
    localparam logic [7:0] ASCII_SLASH   = 8'd47;
    localparam logic [7:0] ASCII_PAD     = 8'd61;
    localparam logic [5:0] VAL_PLUS      = 6'd62;
    localparam logic [5:0] VAL_SLASH     = 6'd63;

    typedef enum logic [1:0] {SLOT_0, SLOT_1, SLOT_2, SLOT_3} slot_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    base64_stream_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 aclk = ~aclk;

    // Decoder state mirrored on the testbench side.
    slot_t      group_slot = SLOT_0;
    bit         group_halted = 1'b0;
    logic [5:0] leftover_bits = '0;
    logic [7:0] pending_bytes[$];

    int  mismatches = 0;
    int  chars_sent = 0;
    int  bytes_checked = 0;
    int  idle_cycles = 0;
    int  ready_hold = 0;
    bit  sender_idle_on = 1'b0;
    bit  receiver_idle_on = 1'b0;
    logic [7:0] wanted_byte;

    function automatic bit char_to_sextet(input logic [7:0] ch, output logic [5:0] val);
        logic [7:0] t;
        val = '0;
        if (ch inside {[8'd65:8'd90]}) begin
            t = ch - ASCII_UPPER_A;
        end else if (ch inside {[8'd97:8'd122]}) begin
            t = ch - ASCII_LOWER_A + 8'd26;
        end else if (ch inside {[8'd48:8'd57]}) begin
            t = ch - ASCII_ZERO + 8'd52;
        end else if (ch == ASCII_PLUS) begin
            t = {2'b00, VAL_PLUS};
        end else if (ch == ASCII_SLASH) begin
            t = {2'b00, VAL_SLASH};
        end else begin
            return 1'b0;
        end
        val = t[5:0];
        return 1'b1;
    endfunction

    function automatic logic [7:0] sextet_to_char(input logic [5:0] val);
        if (val < 6'd26) return ASCII_UPPER_A + 8'(val);
        if (val < 6'd52) return ASCII_LOWER_A + 8'(val - 6'd26);
        if (val < VAL_PLUS) return ASCII_ZERO + 8'(val - 6'd52);
        if (val == VAL_PLUS) return ASCII_PLUS;
        return ASCII_SLASH;
    endfunction

    // Advance the mirrored decoder by one accepted character; queue any byte it completes.
    function automatic void decode_char(input logic [7:0] ch);
        logic [5:0] val;
        if (!group_halted) begin
            if (!char_to_sextet(ch, val)) begin
                group_halted = 1'b1;
            end else begin
                case (group_slot)
                    SLOT_0: begin
                        leftover_bits = val;
                    end
                    SLOT_1: begin
                        pending_bytes.push_back({leftover_bits, val[5:4]});
                        leftover_bits = {2'b00, val[3:0]};
                    end
                    SLOT_2: begin
                        pending_bytes.push_back({leftover_bits[3:0], val[5:2]});
                        leftover_bits = {4'b0000, val[1:0]};
                    end
                    default: begin
                        pending_bytes.push_back({leftover_bits[1:0], val});
                        leftover_bits = '0;
                    end
                endcase
            end
        end
        if (group_slot == SLOT_3) begin
            group_slot = SLOT_0;
            group_halted = 1'b0;
            leftover_bits = '0;
        end else begin
            group_slot = slot_t'(group_slot + 2'd1);
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch: %s, got %02h want %02h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Offer one character and hold it until the transfer happens.
    task automatic send_char(input logic [7:0] ch);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        decode_char(ch);
        chars_sent++;
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_string(input string text);
        for (int i = 0; i < text.len(); i++) send_char(text[i]);
    endtask

    // Encode a random byte string with proper padding; optionally corrupt or drop characters.
    task automatic send_text(input int nbytes, input bit damage);
        logic [7:0]  raw[$];
        logic [23:0] chunk;
        logic [7:0]  ch;
        int          take;
        for (int i = 0; i < nbytes; i++) raw.push_back(8'($urandom));
        for (int i = 0; i < nbytes; i += 3) begin
            take  = (nbytes - i >= 3) ? 3 : nbytes - i;
            chunk = {raw[i], (take > 1) ? raw[i+1] : 8'h00, (take > 2) ? raw[i+2] : 8'h00};
            for (int k = 0; k < 4; k++) begin
                ch = (k <= take) ? sextet_to_char(chunk[23-6*k -: 6]) : ASCII_PAD;
                if (damage && $urandom_range(0, 29) == 0) continue;
                if (damage && $urandom_range(0, 11) == 0) ch = 8'($urandom);
                send_char(ch);
            end
        end
    endtask

    task automatic test_directed_groups();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        // Alphabet extremes, both paddings, and a group holding a single valid character.
        send_string("AZaz09+/QQ==QUI=");
        send_char("Q");
        send_char(8'hFF);
        send_string("==");
        // An invalid first character makes the whole group produce nothing.
        send_char(8'hFF);
        send_string("ABC");
        // Zero byte stops a group late, after one byte already came out.
        send_string("/+");
        send_char(8'h00);
        send_char("A");
    endtask

    task automatic test_full_rate_text();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        for (int n = 0; n < 30; n++) send_text($urandom_range(1, 7), 1'b0);
    endtask

    task automatic test_text_with_idling();
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        for (int n = 0; n < 120; n++) send_text($urandom_range(1, 7), 1'b0);
    endtask

    task automatic test_noise_and_damage();
        logic [7:0] edges[10] = '{8'd64, 8'd91, 8'd96, 8'd123, 8'd58, 8'd47,
                                  8'd42, 8'd44, 8'd46, 8'd61};
        logic [7:0] ch;
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        for (int n = 0; n < 20; n++) send_text($urandom_range(1, 9), 1'b1);
        for (int n = 0; n < 400; n++) begin
            case ($urandom_range(0, 3))
                0:       ch = 8'($urandom);
                1:       ch = edges[$urandom_range(0, 9)];
                default: ch = sextet_to_char(6'($urandom));
            endcase
            send_char(ch);
        end
    endtask

    // Result side: random stalls while idling is enabled, steady ready otherwise.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_axis_tready <= 1'b0;
        end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
            ready_hold = pick_gap() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch("byte with nothing pending", m_axis_tdata, 8'h00);
            end else begin
                wanted_byte = pending_bytes.pop_front();
                if (m_axis_tdata !== wanted_byte)
                    report_mismatch("data_byte", m_axis_tdata, wanted_byte);
                bytes_checked++;
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_groups();
        test_full_rate_text();
        test_text_with_idling();
        test_noise_and_damage();

        s_axis_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d characters and %0d decoded bytes", chars_sent, bytes_checked);
        $display("padding, invalid and misaligned groups, both sides stalling and not");
        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_fifo.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder.sv
dv/testbench.sv
